// ===== rtl/kc_pkg.sv =====
// Shared constants, command codes, control structs and k-mer helper functions.
package kc_pkg;

  localparam int MAX_KMER_LEN = 6;
  localparam int COUNT_W      = 32;
  localparam int KEY_W        = 2 * MAX_KMER_LEN;
  localparam int ADDR_W       = KEY_W;
  localparam int TABLE_DEPTH  = 1 << ADDR_W;
  localparam int K_W          = 3;
  localparam int CMD_W        = 2;
  localparam int BASE_W       = 8;

  localparam logic [K_W-1:0]     K_RESET   = 3'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BASE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              accept;
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
    logic              lookup;
    logic              finish;
  } kc_ctrl_t;

  // Status from the datapath, valid while a word is offered.
  typedef struct packed {
    logic is_restart;
    logic need_lookup;
  } kc_stat_t;

  // Clamp the programmed k into 1..MAX_KMER_LEN.
  function automatic logic [K_W-1:0] eff_k(input logic [K_W-1:0] k);
    logic [K_W-1:0] res;
    res = k;
    if (k == '0) begin
      res = K_W'(1);
    end else if (k > K_W'(MAX_KMER_LEN)) begin
      res = K_W'(MAX_KMER_LEN);
    end
    return res;
  endfunction

  // Low 2k bits set.
  function automatic logic [KEY_W-1:0] key_mask(input logic [K_W-1:0] k);
    logic [KEY_W-1:0] ones;
    ones = '1;
    return ~(ones << {k, 1'b0});
  endfunction

  // Smaller of a k-mer and its reverse complement.
  function automatic logic [KEY_W-1:0] canonical(input logic [KEY_W-1:0] x,
                                                 input logic [K_W-1:0]   k);
    logic [KEY_W-1:0] rev;
    logic [KEY_W-1:0] rc;
    logic [K_W:0]     sh;
    rev = '0;
    for (int i = 0; i < MAX_KMER_LEN; i++) begin
      rev[2*(MAX_KMER_LEN-1-i) +: 2] = ~x[2*i +: 2];
    end
    sh = (K_W+1)'(MAX_KMER_LEN) - {1'b0, k};
    rc = rev >> {sh, 1'b0};
    return (rc < x) ? rc : x;
  endfunction

  // Number of canonical classes: (4^k + palindromes) / 2.
  function automatic logic [COUNT_W-1:0] class_num(input logic [K_W-1:0] k);
    logic [KEY_W+1:0] all_km;
    logic [KEY_W+1:0] pal;
    all_km = (KEY_W+2)'(1) << {k, 1'b0};
    pal    = k[0] ? '0 : ((KEY_W+2)'(1) << k);
    return COUNT_W'((all_km + pal) >> 1);
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

endpackage

// ===== rtl/kc_in_if.sv =====
// Input channel: command words with valid/ready handshake.
interface kc_in_if;
  logic                      valid;
  logic                      ready;
  logic [kc_pkg::CMD_W-1:0]  cmd;
  logic [kc_pkg::BASE_W-1:0] base;
  logic [kc_pkg::KEY_W-1:0]  query_kmer;

  modport source (output valid, cmd, base, query_kmer, input ready);
  modport sink   (input valid, cmd, base, query_kmer, output ready);
endinterface

// ===== rtl/kc_out_if.sv =====
// Result channel: count words with valid/ready handshake.
interface kc_out_if;
  logic                       valid;
  logic                       ready;
  logic [kc_pkg::COUNT_W-1:0] class_count;
  logic [kc_pkg::COUNT_W-1:0] total_count;
  logic                       counted;

  modport source (output valid, class_count, total_count, counted, input ready);
  modport sink   (input valid, class_count, total_count, counted, output ready);
endinterface

// ===== rtl/canonical_kmer_counter.sv =====
// A base that completes no counted window, or an unused command, goes from acceptance
// straight to the result state; a counted base or a query first takes one table read.
// One word is taken at a time; the next is accepted once the result register is loaded.
// A restart runs a clearing pass over all 4096 table entries, then gives its result.
// Reset (synchronous, rst_n low) sets k to 4 and runs the same clearing pass, during
// which no word is accepted; configuration writes are taken whenever rst_n is high.
module canonical_kmer_counter (
  input  logic                   clk,
  input  logic                   rst_n,
  kc_in_if.sink                  in_ch,
  kc_out_if.source               out_ch,
  input  logic                   cfg_we,
  input  logic [kc_pkg::K_W-1:0] cfg_wdata
);

  // The controller decides when a word is taken, when the count table is
  // read and when a result moves into the output register. It never looks at
  // the payload; the datapath reports what the offered word will need.
  kc_pkg::kc_ctrl_t ctrl;
  kc_pkg::kc_stat_t stat;

  kc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // The datapath holds the rolling key and ambiguity mask, the total, the
  // 4096-entry count table addressed by canonical value, and the result word.
  // The output register lets a new word be accepted while a result waits.
  kc_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .in_cmd          (in_ch.cmd),
    .in_base         (in_ch.base),
    .in_query_kmer   (in_ch.query_kmer),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .res_class_count (out_ch.class_count),
    .res_total_count (out_ch.total_count),
    .res_counted     (out_ch.counted)
  );

endmodule

// ===== rtl/kc_datapath.sv =====
// Datapath: k-mer window, count table, total and result registers.
module kc_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kc_pkg::kc_ctrl_t           ctrl,
  output kc_pkg::kc_stat_t           stat,
  input  logic [kc_pkg::CMD_W-1:0]   in_cmd,
  input  logic [kc_pkg::BASE_W-1:0]  in_base,
  input  logic [kc_pkg::KEY_W-1:0]   in_query_kmer,
  input  logic                       cfg_we,
  input  logic [kc_pkg::K_W-1:0]     cfg_wdata,
  output logic [kc_pkg::COUNT_W-1:0] res_class_count,
  output logic [kc_pkg::COUNT_W-1:0] res_total_count,
  output logic                       res_counted
);

  logic [kc_pkg::COUNT_W-1:0] mem [kc_pkg::TABLE_DEPTH];

  logic [kc_pkg::K_W-1:0]     k_r;
  logic [kc_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [kc_pkg::KEY_W-1:0]   amb_r, amb_nxt;
  logic [kc_pkg::K_W-1:0]     fill_r, fill_nxt, fill_clip;
  logic [kc_pkg::COUNT_W-1:0] total_r;
  logic [kc_pkg::KEY_W-1:0]   lookup_key_r;
  logic [kc_pkg::CMD_W-1:0]   op_r;
  logic                       counted_r;
  logic [kc_pkg::ADDR_W-1:0]  addr_r;
  logic [kc_pkg::COUNT_W-1:0] rdata_r;
  logic [kc_pkg::COUNT_W-1:0] cc_r, tot_out_r;
  logic                       cnt_out_r;

  logic [kc_pkg::K_W-1:0]     k_eff;
  logic [kc_pkg::KEY_W-1:0]   km;
  logic [kc_pkg::ADDR_W-1:0]  canon_addr;
  logic                       will_count;
  logic                       bump;
  logic [kc_pkg::COUNT_W-1:0] rdata_inc, total_inc;

  assign k_eff = kc_pkg::eff_k(k_r);
  assign km    = kc_pkg::key_mask(k_eff);

  always_comb begin
    key_nxt   = {key_r[kc_pkg::KEY_W-3:0], in_base[1:0]} & km;
    amb_nxt   = {amb_r[kc_pkg::KEY_W-3:0], 1'b0, |in_base[kc_pkg::BASE_W-1:2]} & km;
    fill_clip = (fill_r > k_eff) ? k_eff : fill_r;
    fill_nxt  = (fill_clip < k_eff) ? fill_clip + kc_pkg::K_W'(1) : fill_clip;
  end

  assign will_count = (in_cmd == kc_pkg::CMD_BASE) && (fill_nxt == k_eff) && (amb_nxt == '0);
  assign stat.is_restart  = (in_cmd == kc_pkg::CMD_RESTART);
  assign stat.need_lookup = will_count || (in_cmd == kc_pkg::CMD_QUERY);

  assign canon_addr = kc_pkg::canonical(lookup_key_r, k_eff);
  assign rdata_inc  = kc_pkg::sat_inc(rdata_r);
  assign total_inc  = kc_pkg::sat_inc(total_r);
  assign bump       = (op_r == kc_pkg::CMD_BASE) && counted_r;

  // Window state and total.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= kc_pkg::K_RESET;
      key_r   <= '0;
      amb_r   <= '0;
      fill_r  <= '0;
      total_r <= kc_pkg::class_num(kc_pkg::K_RESET);
    end else begin
      if (cfg_we) begin
        k_r <= cfg_wdata;
      end
      if (ctrl.accept) begin
        unique case (in_cmd)
          kc_pkg::CMD_RESTART: begin
            key_r   <= '0;
            amb_r   <= '0;
            fill_r  <= '0;
            total_r <= kc_pkg::class_num(k_eff);
          end
          kc_pkg::CMD_BASE: begin
            key_r  <= key_nxt;
            amb_r  <= amb_nxt;
            fill_r <= fill_nxt;
          end
          default: begin
          end
        endcase
      end else if (ctrl.finish && bump) begin
        total_r <= total_inc;
      end
    end
  end

  // Per-word payload registers.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      op_r         <= in_cmd;
      counted_r    <= will_count;
      lookup_key_r <= (in_cmd == kc_pkg::CMD_BASE) ? key_nxt : (in_query_kmer & km);
    end
    if (ctrl.lookup) begin
      addr_r <= canon_addr;
    end
    if (ctrl.finish) begin
      cnt_out_r <= bump;
      tot_out_r <= bump ? total_inc : total_r;
      if (bump) begin
        cc_r <= rdata_inc;
      end else if (op_r == kc_pkg::CMD_QUERY) begin
        cc_r <= rdata_r;
      end else begin
        cc_r <= '0;
      end
    end
  end

  // Count table: one write port (clearing pass or increment), one registered read.
  always_ff @(posedge clk) begin
    if (ctrl.clr_we) begin
      mem[ctrl.clr_addr] <= kc_pkg::COUNT_W'(1);
    end else if (ctrl.finish && bump) begin
      mem[addr_r] <= rdata_inc;
    end
    if (ctrl.lookup) begin
      rdata_r <= mem[canon_addr];
    end
  end

  assign res_class_count = cc_r;
  assign res_total_count = tot_out_r;
  assign res_counted     = cnt_out_r;

endmodule

// ===== rtl/kc_ctrl.sv =====
// Controller: sequences clearing pass, table lookup and result hand-off.
module kc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  kc_pkg::kc_stat_t stat,
  output kc_pkg::kc_ctrl_t ctrl
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_FIN
  } state_t;

  state_t                    state_r, state_nxt;
  logic [kc_pkg::ADDR_W-1:0] clr_cnt_r;
  logic                      report_r;
  logic                      in_ready_r;
  logic                      out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    ctrl.accept   = 1'b0;
    ctrl.clr_we   = 1'b0;
    ctrl.clr_addr = clr_cnt_r;
    ctrl.lookup   = 1'b0;
    ctrl.finish   = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ctrl.clr_we = 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = report_r ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          ctrl.accept = 1'b1;
          if (stat.is_restart) begin
            state_nxt = S_CLEAR;
          end else if (stat.need_lookup) begin
            state_nxt = S_LOOK;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_LOOK: begin
        ctrl.lookup = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          ctrl.finish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      report_r    <= 1'b0;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
      clr_cnt_r  <= (state_r == S_CLEAR) ? clr_cnt_r + kc_pkg::ADDR_W'(1) : '0;
      if (ctrl.accept) begin
        report_r <= stat.is_restart;
      end
      if (ctrl.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/kc_checker.sv =====
// Port-level checker for the canonical k-mer counter, bound to the top level.
module kc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [kc_pkg::COUNT_W-1:0] class_count,
  input logic [kc_pkg::COUNT_W-1:0] total_count,
  input logic                       counted
);

  // A waiting result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A waiting result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(class_count) && $stable(total_count) && $stable(counted))
    else $error("result changed while stalled");

  // One word at a time: after a word is taken the block is busy.
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while busy");

  // A counted window adds to a class that already holds its pseudocount.
  a_counted_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && counted |-> class_count >= kc_pkg::COUNT_W'(2))
    else $error("counted class below two");

endmodule

bind canonical_kmer_counter kc_checker u_kc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .class_count (out_ch.class_count),
  .total_count (out_ch.total_count),
  .counted     (out_ch.counted)
);

// ===== tb/kmer_tally_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard that predicts every result word of the canonical k-mer counter and compares it.
module kmer_tally_checker
  import kc_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  kc_in_if               in_ch,
  kc_out_if              out_ch,
  input  logic           cfg_we,
  input  logic [K_W-1:0] cfg_wdata,
  output int             mismatches,
  output int             pending_words,
  output int             words_checked,
  output int             windows_counted
);

  localparam int REPORT_CAP = 40;

  typedef struct packed {
    logic [COUNT_W-1:0] class_count;
    logic [COUNT_W-1:0] total_count;
    logic               counted;
  } count_word_t;

  count_word_t        expected_words[$];
  logic [COUNT_W-1:0] class_tally [TABLE_DEPTH];
  logic [KEY_W-1:0]   window_key;
  logic [KEY_W-1:0]   ambig_mask;
  int unsigned        bases_held;
  logic [COUNT_W-1:0] running_total;
  logic [K_W-1:0]     k_setting;
  int                 fail_count;
  int                 checked_cnt;
  int                 counted_cnt;

  // A setting of zero behaves as one, anything above the maximum as the maximum.
  function automatic int unsigned active_k(input logic [K_W-1:0] setting);
    if (setting == '0) return 1;
    if (setting > K_W'(MAX_KMER_LEN)) return MAX_KMER_LEN;
    return int'(setting);
  endfunction

  function automatic logic [KEY_W-1:0] window_bits(input int unsigned k);
    return KEY_W'((64'd1 << (2 * k)) - 64'd1);
  endfunction

  // Reverse complement built base by base from the low end, then the smaller one wins.
  function automatic logic [KEY_W-1:0] canonical_of(input logic [KEY_W-1:0] kmer,
                                                    input int unsigned k);
    logic [KEY_W-1:0] revcomp;
    revcomp = '0;
    for (int i = 0; i < int'(k); i++) begin
      revcomp = {revcomp[KEY_W-3:0], 2'b11 - kmer[2*i +: 2]};
    end
    return (revcomp < kmer) ? revcomp : kmer;
  endfunction

  // Classes: half of all k-mers plus half of the palindromes, which exist for even k only.
  function automatic logic [COUNT_W-1:0] class_total(input int unsigned k);
    logic [63:0] all_kmers;
    logic [63:0] palindromes;
    all_kmers   = 64'd1 << (2 * k);
    palindromes = (k % 2 == 0) ? (64'd1 << k) : 64'd0;
    return COUNT_W'((all_kmers + palindromes) / 2);
  endfunction

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (&v) ? v : v + COUNT_W'(1);
  endfunction

  function automatic void restart_tally();
    foreach (class_tally[i]) class_tally[i] = COUNT_W'(1);
    window_key    = '0;
    ambig_mask    = '0;
    bases_held    = 0;
    running_total = class_total(active_k(k_setting));
  endfunction

  function automatic count_word_t predict_word(input logic [CMD_W-1:0]  cmd,
                                               input logic [BASE_W-1:0] base,
                                               input logic [KEY_W-1:0]  query);
    count_word_t      word;
    int unsigned      k;
    logic [KEY_W-1:0] keep;
    logic [KEY_W-1:0] cls;
    k    = active_k(k_setting);
    keep = window_bits(k);
    word = '0;
    case (cmd)
      CMD_RESTART: restart_tally();
      CMD_BASE: begin
        window_key = {window_key[KEY_W-3:0], base[1:0]} & keep;
        ambig_mask = {ambig_mask[KEY_W-3:0], 1'b0, |base[BASE_W-1:2]} & keep;
        if (bases_held > k) bases_held = k;
        if (bases_held < k) bases_held++;
        if (bases_held == k && ambig_mask == '0) begin
          cls              = canonical_of(window_key, k);
          class_tally[cls] = bump(class_tally[cls]);
          running_total    = bump(running_total);
          word.class_count = class_tally[cls];
          word.counted     = 1'b1;
        end
      end
      CMD_QUERY: word.class_count = class_tally[canonical_of(query & keep, k)];
      default: ;
    endcase
    word.total_count = running_total;
    return word;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < REPORT_CAP) $display("%0t checker: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    count_word_t want;
    count_word_t got;
    if (!rst_n) begin
      k_setting = K_RESET;
      restart_tally();
      expected_words.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.class_count = out_ch.class_count;
        got.total_count = out_ch.total_count;
        got.counted     = out_ch.counted;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word with nothing pending (class_count %0d)",
                                    got.class_count));
        end else begin
          want = expected_words.pop_front();
          if (got.class_count !== want.class_count)
            report_mismatch($sformatf("word %0d: class_count %0d, expected %0d",
                                      checked_cnt, got.class_count, want.class_count));
          if (got.total_count !== want.total_count)
            report_mismatch($sformatf("word %0d: total_count %0d, expected %0d",
                                      checked_cnt, got.total_count, want.total_count));
          if (got.counted !== want.counted)
            report_mismatch($sformatf("word %0d: counted %b, expected %b",
                                      checked_cnt, got.counted, want.counted));
          checked_cnt++;
          if (want.counted) counted_cnt++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_words.insert(expected_words.size(),
                              predict_word(in_ch.cmd, in_ch.base, in_ch.query_kmer));
      end
      if (cfg_we) k_setting = cfg_wdata;
    end
    mismatches      <= fail_count;
    pending_words   <= expected_words.size();
    words_checked   <= checked_cnt;
    windows_counted <= counted_cnt;
  end

endmodule

// ===== tb/canonical_kmer_counter_tb.sv =====
`timescale 1ns / 1ps
// Top of the canonical k-mer counter testbench: clock, reset, stimulus, back-pressure, verdict.
module canonical_kmer_counter_tb;
  import kc_pkg::*;

  // Command code 3 has no function in the block; it must leave the state alone.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // No word moving on either channel for this many cycles means the block hung. The
  // longest legal quiet stretch is a clearing pass over the whole count table plus
  // latency, sender gap and receiver stall, so this leaves a wide margin.
  localparam int STALL_LIMIT = 20000;

  // The random part runs in phases, one k setting each. The list covers both
  // out-of-range settings (0 and 7) and every legal k. Even phases open with a restart,
  // so the class number is checked for that k; odd phases keep the window and the
  // counts, so the new k takes over mid-stream (growing from 1 to 6, shrinking from
  // 2 to 1, from 6 to 3 and from 5 to 4).
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_WORDS = 128;
  localparam logic [K_W-1:0] PHASE_K [NUM_PHASES] =
    '{3'd0, 3'd7, 3'd2, 3'd1, 3'd6, 3'd3, 3'd5, 3'd4};

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           cfg_we    = 1'b0;
  logic [K_W-1:0] cfg_wdata = K_RESET;

  kc_in_if  in_ch();
  kc_out_if out_ch();

  int mismatches;
  int pending_words;
  int words_checked;
  int windows_counted;

  // Sender bookkeeping: words left in the current burst, the last bases sent (used to
  // aim queries at windows that were actually counted) and per-command tallies.
  int               burst_left   = 0;
  logic [KEY_W-1:0] recent_bases = '0;
  int               n_bases      = 0;
  int               n_queries    = 0;
  int               n_restarts   = 0;
  int               n_unused     = 0;
  int               idle_cycles  = 0;

  // Receiver back-pressure: an 8-bit ready pattern that is replaced every so often.
  // A third of the patterns are all ones, giving long stretches without stalls; the
  // others always keep bit 0 set, so the receiver is ready in every pass of the pattern.
  logic        ready_q       = 1'b0;
  logic [7:0]  stall_pattern = 8'hff;
  int          pattern_left  = 0;
  int unsigned pattern_pos   = 0;

  assign out_ch.ready = ready_q;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  canonical_kmer_counter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  kmer_tally_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .pending_words   (pending_words),
    .words_checked   (words_checked),
    .windows_counted (windows_counted)
  );

  always @(posedge clk) begin
    if (pattern_left == 0) begin
      stall_pattern <= ($urandom_range(0, 2) == 0) ? 8'hff : (8'($urandom) | 8'h01);
      pattern_left  <= $urandom_range(16, 160);
    end else begin
      pattern_left <= pattern_left - 1;
    end
    pattern_pos <= pattern_pos + 1;
    ready_q     <= stall_pattern[pattern_pos % 8];
  end

  // Watchdog: counts cycles in which no word is accepted on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("Timeout: no word accepted for %0d cycles, %0d results still pending.",
               STALL_LIMIT, pending_words);
      $display("[canonical_kmer_counter] ERROR");
      $finish;
    end
  end

  // Offers one word and returns at the edge where it is accepted. Words go out in
  // bursts of random length; between bursts valid drops for a random gap, and a gap
  // of zero lets two bursts run together. A word that directly follows another keeps
  // valid high without lowering it in between.
  task automatic send_word(input logic [CMD_W-1:0]  cmd,
                           input logic [BASE_W-1:0] base,
                           input logic [KEY_W-1:0]  query);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.base       <= base;
    in_ch.query_kmer <= query;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    case (cmd)
      CMD_RESTART: n_restarts++;
      CMD_BASE: begin
        n_bases++;
        recent_bases = {recent_bases[KEY_W-3:0], base[1:0]};
      end
      CMD_QUERY: n_queries++;
      default: n_unused++;
    endcase
  endtask

  // One random word for effective length k. Most words are clean bases, a quarter of
  // those repeating the previous code so that homopolymer runs count the same class
  // many times even at k = 6. Some bases are fully random bytes, which are nearly
  // always ambiguous. Queries ask either a random k-mer or the current window, the
  // latter with random upper bits to show that only the low 2k bits matter. Restarts
  // are rare because each one costs a full clearing pass.
  task automatic send_random_word(input int unsigned k);
    int unsigned      pick;
    logic [BASE_W-1:0] b;
    logic [KEY_W-1:0]  q;
    logic [KEY_W-1:0]  keep;
    keep = KEY_W'((32'd1 << (2 * k)) - 32'd1);
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      send_word(CMD_RESTART, BASE_W'($urandom_range(0, 255)), KEY_W'($urandom_range(0, 4095)));
    end else if (pick < 4) begin
      send_word(CMD_UNUSED, BASE_W'($urandom_range(0, 255)), KEY_W'($urandom_range(0, 4095)));
    end else if (pick < 16) begin
      q = KEY_W'($urandom_range(0, 4095));
      if ($urandom_range(0, 1) == 1) q = (q & ~keep) | (recent_bases & keep);
      send_word(CMD_QUERY, BASE_W'($urandom_range(0, 255)), q);
    end else begin
      if (pick < 24) begin
        b = BASE_W'($urandom_range(0, 255));
      end else if (pick < 44) begin
        b = {{(BASE_W-2){1'b0}}, recent_bases[1:0]};
      end else begin
        b = BASE_W'($urandom_range(0, 3));
      end
      send_word(CMD_BASE, b, KEY_W'($urandom_range(0, 4095)));
    end
  endtask

  // Stops offering words and waits until every expected result has come back, then
  // lets the block's latency pass so that nothing is left in flight.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_words != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_kmer_length(input logic [K_W-1:0] k);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned k;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_BASE;
    in_ch.base       <= '0;
    in_ch.query_kmer <= '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset length k = 4 (136 classes). The first word waits out
    // the clearing pass that follows reset.
    send_word(CMD_QUERY, 8'h00, 12'h000);
    send_word(CMD_QUERY, 8'hff, 12'hfff);
    // The unused command with every payload bit set must change nothing.
    send_word(CMD_UNUSED, 8'hff, 12'hfff);
    // Four A's fill the window; the fourth counts class AAAA, the smallest key.
    repeat (4) send_word(CMD_BASE, 8'h00, 12'hfff);
    // AAAT is counted as well.
    send_word(CMD_BASE, 8'h03, 12'h000);
    // An all-ones byte is ambiguous with code T; then each upper bit alone is
    // ambiguous too, so none of these windows may count.
    send_word(CMD_BASE, 8'hff, 12'h000);
    for (int i = 2; i < BASE_W; i++) send_word(CMD_BASE, BASE_W'(1) << i, 12'h000);
    // Four clean bases flush the ambiguity; CGTA is counted on the last one.
    send_word(CMD_BASE, 8'h01, 12'h000);
    send_word(CMD_BASE, 8'h02, 12'h000);
    send_word(CMD_BASE, 8'h03, 12'h000);
    send_word(CMD_BASE, 8'h00, 12'h000);
    // TTTT shares its class with AAAA; the upper query bits are ignored at k = 4.
    send_word(CMD_QUERY, 8'h00, 12'hfff);
    // A restart presets every count and the total, and empties the window.
    send_word(CMD_RESTART, 8'hff, 12'hfff);
    send_word(CMD_QUERY, 8'h00, 12'h000);
    send_word(CMD_BASE, 8'h00, 12'h000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_kmer_length(PHASE_K[p]);
      k = (PHASE_K[p] == '0) ? 1 :
          (PHASE_K[p] > K_W'(MAX_KMER_LEN)) ? MAX_KMER_LEN : int'(PHASE_K[p]);
      if (p % 2 == 0) send_word(CMD_RESTART, 8'h00, 12'h000);
      repeat (PHASE_WORDS) send_random_word(k);
    end

    drain_results();

    $display("Sent %0d bases, %0d queries, %0d restarts and %0d unused commands over %0d k settings.",
             n_bases, n_queries, n_restarts, n_unused, NUM_PHASES + 1);
    $display("Compared %0d result words, %0d of them counted windows; %0d mismatches.",
             words_checked, windows_counted, mismatches);
    if (mismatches == 0) begin
      $display("[canonical_kmer_counter] OK");
    end else begin
      $display("[canonical_kmer_counter] ERROR");
    end
    $finish;
  end

endmodule
